// ===== sv/cavs_pkg.sv =====
// Shared constants, types and helper functions for the anneal vote stencil.
// No dependencies; the window cell, the top level and the testbench import it.
`timescale 1ns / 1ps

package cavs_pkg;

   // Default grid limits, handed to the top level as parameter defaults.
   localparam int unsigned MAX_ROWS_DEFAULT = 1024;
   localparam int unsigned MAX_COLS_DEFAULT = 1024;

   // Configuration port geometry.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 11;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RULE_TABLE = 2'd2;

   // Field widths of the register file and the result transaction.
   localparam int unsigned SIZE_W  = 11;
   localparam int unsigned RULE_W  = 10;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned SUM_W   = 4;

   // Register reset values; the rule table is the twisted majority vote,
   // next state 1 for neighborhood sums 4, 6, 7, 8 and 9.
   localparam logic [SIZE_W-1:0] GRID_ROWS_RESET  = 11'd1024;
   localparam logic [SIZE_W-1:0] GRID_COLS_RESET  = 11'd1024;
   localparam logic [RULE_W-1:0] RULE_TABLE_RESET = 10'b11_1101_0000;

   // One column of the 3x3 window: upper row in bit 2, current row in bit 0.
   typedef logic [2:0] column_type;

   // Result fields held between the window update and the output register.
   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic               last;
   } stage_type;

   // Number of set bits in one window column.
   function automatic logic [SUM_W-1:0] column_ones(input column_type col);
      column_ones = SUM_W'(col[0]) + SUM_W'(col[1]) + SUM_W'(col[2]);
   endfunction

   // Next state for a neighborhood sum of 0 to 9.
   function automatic logic rule_lookup(input logic [RULE_W-1:0] rule,
                                        input logic [SUM_W-1:0] sum);
      logic bit_out;
      bit_out = 1'b0;
      case (sum)
         4'd0:    bit_out = rule[0];
         4'd1:    bit_out = rule[1];
         4'd2:    bit_out = rule[2];
         4'd3:    bit_out = rule[3];
         4'd4:    bit_out = rule[4];
         4'd5:    bit_out = rule[5];
         4'd6:    bit_out = rule[6];
         4'd7:    bit_out = rule[7];
         4'd8:    bit_out = rule[8];
         4'd9:    bit_out = rule[9];
         default: bit_out = 1'b0;
      endcase
      rule_lookup = bit_out;
   endfunction

endpackage

// ===== sv/cavs_req_if.sv =====
// Input channel interface: one padded-grid cell per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface cavs_req_if;
   logic valid;
   logic ready;
   logic cell_value;

   modport source (output valid, output cell_value, input ready);
   modport sink (input valid, input cell_value, output ready);
endinterface

// ===== sv/cavs_rsp_if.sv =====
// Result channel interface: next state of one interior cell per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface cavs_rsp_if;
   logic       valid;
   logic       ready;
   logic       next_value;
   logic [9:0] cell_row;
   logic [9:0] cell_col;
   logic       frame_last;

   modport source (output valid, output next_value, output cell_row,
                   output cell_col, output frame_last, input ready);
   modport sink (input valid, input next_value, input cell_row,
                 input cell_col, input frame_last, output ready);
endinterface

// ===== sv/cavs_line_mem.sv =====
// Two-row line buffer: one memory word per padded column holding the cells
// of the two previous rows. Registered read; depends on nothing.
`timescale 1ns / 1ps

module cavs_line_mem #(
   parameter int unsigned DEPTH = 1026,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [1:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [1:0]    rd_data
);

   logic [1:0] mem [DEPTH];
   logic [1:0] rd_data_ff;

   // Write port, taken once per accepted cell.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, running every cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cavs_win_cell.sv =====
// One column cell of the 3x3 window: stores a column, hands it to the next
// cell on each shift and adds its set bits to the running sum. Uses cavs_pkg.
`timescale 1ns / 1ps

module cavs_win_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  cavs_pkg::column_type        col_in,
   input  logic [cavs_pkg::SUM_W-1:0]  sum_in,
   output cavs_pkg::column_type        col_out,
   output logic [cavs_pkg::SUM_W-1:0]  sum_out
);
   import cavs_pkg::*;

   column_type col_ff;
   column_type col_in_q;

   // Take the neighbor's column on a shift, otherwise hold.
   assign col_in_q = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_q;
      end
   end

   assign col_out = col_ff;
   assign sum_out = sum_in + column_ones(col_ff);

endmodule

// ===== sv/ca_anneal_vote_stencil.sv =====
// Top level of the anneal vote stencil: counters, line buffer, window chain
// and result register. Uses cavs_pkg, the channel interfaces and submodules.
`timescale 1ns / 1ps

// The block takes one padded-grid cell per cycle in raster order over
// (grid_rows+2) by (grid_cols+2) cells and returns the next state of each
// interior cell, with its row, column and a last-of-generation flag, via the
// window stage and result register once padded cell (row+2, col+2) is taken.
// Every cycle can carry a new cell: the line buffer is read one column
// ahead, so its single write and single read port serve one cell per cycle,
// and the window's three column cells shift once per cell. The result
// register takes a new value while the previous one is being taken, so
// input stalls only while a result waits unclaimed. The line buffer needs
// no clearing after reset; its first two rows are filled before any result
// depends on them. Register writes take effect at once and belong between
// generations, with the block idle.

module ca_anneal_vote_stencil #(
   parameter int unsigned MAX_ROWS = cavs_pkg::MAX_ROWS_DEFAULT,
   parameter int unsigned MAX_COLS = cavs_pkg::MAX_COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   cavs_req_if.sink                          req_chan,
   cavs_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [cavs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cavs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import cavs_pkg::*;

   localparam int unsigned RW    = $clog2(MAX_ROWS + 2);
   localparam int unsigned CW    = $clog2(MAX_COLS + 2);
   localparam int unsigned DEPTH = MAX_COLS + 2;

   // Configuration registers.
   logic [SIZE_W-1:0] grid_rows_ff;
   logic [SIZE_W-1:0] grid_cols_ff;
   logic [RULE_W-1:0] rule_table_ff;

   // Padded position of the next input cell.
   logic [RW-1:0] in_row_count_ff, in_row_count_in;
   logic [CW-1:0] in_col_count_ff, in_col_count_in;

   // Pipeline registers.
   stage_type          stage_ff, stage_in;
   logic               rsp_valid_ff;
   logic               next_value_ff;
   logic [INDEX_W-1:0] cell_row_ff;
   logic [INDEX_W-1:0] cell_col_ff;
   logic               frame_last_ff;

   logic          advance;
   logic          accept;
   logic [RW-1:0] rows_lim;
   logic [CW-1:0] cols_lim;
   logic          row_end;
   logic [CW-1:0] rd_addr;
   logic [1:0]    line_rd;
   column_type    new_col;
   column_type    col0, col1;
   logic [SUM_W-1:0] sum0, sum1, sum2;
   logic [RW-1:0] row_off;
   logic [CW-1:0] col_off;

   // Register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff  <= GRID_ROWS_RESET;
         grid_cols_ff  <= GRID_COLS_RESET;
         rule_table_ff <= RULE_TABLE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_ROWS:  grid_rows_ff  <= csr_wdata;
            CSR_GRID_COLS:  grid_cols_ff  <= csr_wdata;
            CSR_RULE_TABLE: rule_table_ff <= csr_wdata[RULE_W-1:0];
            default: ;
         endcase
      end
   end

   // Last padded index of a row and of a frame, with sizes clamped to 1..MAX.
   always_comb begin
      if (grid_rows_ff == '0) begin
         rows_lim = RW'(2);
      end else if (32'(grid_rows_ff) > 32'(MAX_ROWS)) begin
         rows_lim = RW'(MAX_ROWS + 1);
      end else begin
         rows_lim = RW'(grid_rows_ff) + RW'(1);
      end
      if (grid_cols_ff == '0) begin
         cols_lim = CW'(2);
      end else if (32'(grid_cols_ff) > 32'(MAX_COLS)) begin
         cols_lim = CW'(MAX_COLS + 1);
      end else begin
         cols_lim = CW'(grid_cols_ff) + CW'(1);
      end
   end

   // Handshake: the whole pipeline moves when the result register is free.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   // Raster position of the next cell.
   assign row_end = (in_col_count_ff >= cols_lim);

   always_comb begin
      in_row_count_in = in_row_count_ff;
      in_col_count_in = in_col_count_ff;
      if (accept) begin
         if (row_end) begin
            in_col_count_in = '0;
            in_row_count_in = (in_row_count_ff >= rows_lim) ? '0
                              : in_row_count_ff + RW'(1);
         end else begin
            in_col_count_in = in_col_count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_count_ff <= '0;
         in_col_count_ff <= '0;
      end else begin
         in_row_count_ff <= in_row_count_in;
         in_col_count_ff <= in_col_count_in;
      end
   end

   // Line buffer, read one column ahead so the data waits for the next cell.
   assign rd_addr = in_col_count_in;

   cavs_line_mem #(
      .DEPTH (DEPTH),
      .AW    (CW)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (in_col_count_ff),
      .wr_data ({line_rd[0], req_chan.cell_value}),
      .rd_addr (rd_addr),
      .rd_data (line_rd)
   );

   // Column entering the window: two rows above, one row above, current.
   assign new_col = {line_rd[1], line_rd[0], req_chan.cell_value};

   // Window chain: newest column first; the sum runs down the chain.
   cavs_win_cell u_cell0 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .col_in   (new_col),
      .sum_in   ('0),
      .col_out  (col0),
      .sum_out  (sum0)
   );

   cavs_win_cell u_cell1 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .col_in   (col0),
      .sum_in   (sum0),
      .col_out  (col1),
      .sum_out  (sum1)
   );

   cavs_win_cell u_cell2 (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .col_in   (col1),
      .sum_in   (sum1),
      .col_out  (),
      .sum_out  (sum2)
   );

   // Result position of the accepted cell; halo cells give no result.
   assign row_off = in_row_count_ff - RW'(2);
   assign col_off = in_col_count_ff - CW'(2);

   always_comb begin
      stage_in.valid = accept && (in_row_count_ff >= RW'(2))
                       && (in_col_count_ff >= CW'(2))
                       && (in_row_count_ff <= rows_lim)
                       && (in_col_count_ff <= cols_lim);
      stage_in.row   = INDEX_W'(row_off);
      stage_in.col   = INDEX_W'(col_off);
      stage_in.last  = (in_row_count_ff == rows_lim) && (in_col_count_ff == cols_lim);
   end

   // Window stage: holds the result position while the window settles.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   // Result register: rule lookup on the neighborhood sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         next_value_ff <= rule_lookup(rule_table_ff, sum2);
         cell_row_ff   <= stage_ff.row;
         cell_col_ff   <= stage_ff.col;
         frame_last_ff <= stage_ff.last;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.next_value = next_value_ff;
   assign rsp_chan.cell_row   = cell_row_ff;
   assign rsp_chan.cell_col   = cell_col_ff;
   assign rsp_chan.frame_last = frame_last_ff;

endmodule

// ===== test/tb_ca_anneal_vote_stencil.sv =====
// Self-checking testbench for the anneal vote stencil: streams padded frames of random
// cells under many grid sizes and rule tables, and predicts every interior result.
// Depends on cavs_pkg, cavs_req_if, cavs_rsp_if and ca_anneal_vote_stencil.
`timescale 1ns / 1ps

module tb_ca_anneal_vote_stencil;
   import cavs_pkg::*;

   // Cycles without any accepted transaction before the run is declared hung.
   localparam int unsigned HANG_LIMIT = 2000;
   // Receiver hold-off that is long enough to fill the block and stall its input.
   localparam int unsigned LONG_HOLD = 200;
   // Cycles to let the pipeline settle after the last expected result.
   localparam int unsigned SETTLE_CYCLES = 8;
   // Input cells spent on random grids.
   localparam int unsigned RANDOM_CELLS = 750;

   typedef struct packed {
      logic               next_value;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
      logic               last;
   } cell_state_type;

   // Tracks the register file, both line buffers, the window and the raster position.
   // It queues the next state of each interior cell and checks results in order.
   class vote_scoreboard_type;
      localparam int unsigned LINE_DEPTH = MAX_COLS_DEFAULT + 2;

      logic [SIZE_W-1:0] grid_rows = GRID_ROWS_RESET;
      logic [SIZE_W-1:0] grid_cols = GRID_COLS_RESET;
      logic [RULE_W-1:0] rule_table = RULE_TABLE_RESET;
      bit                older_row [LINE_DEPTH];
      bit                newer_row [LINE_DEPTH];
      logic [8:0]        window = '0;
      int unsigned       pad_row = 0;
      int unsigned       pad_col = 0;
      cell_state_type    next_states [$];
      int                errors = 0;

      // Sizes of zero act as one; sizes beyond the limit act as the limit.
      function int unsigned clamp(input logic [SIZE_W-1:0] v, input int unsigned limit);
         if (v == 0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function int unsigned frame_cells();
         return (clamp(grid_rows, MAX_ROWS_DEFAULT) + 2) *
                (clamp(grid_cols, MAX_COLS_DEFAULT) + 2);
      endfunction

      function int pending();
         return next_states.size();
      endfunction

      function void write_reg(input logic [CSR_INDEX_W-1:0] index,
                              input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GRID_ROWS:  grid_rows = data;
            CSR_GRID_COLS:  grid_cols = data;
            CSR_RULE_TABLE: rule_table = data[RULE_W-1:0];
            default: ;
         endcase
      endfunction

      // Called for every accepted input transaction.
      function void note_cell(input logic cell_bit);
         int unsigned    rows;
         int unsigned    cols;
         int unsigned    r;
         int unsigned    c;
         logic           up;
         logic           mid;
         cell_state_type res;
         rows = clamp(grid_rows, MAX_ROWS_DEFAULT);
         cols = clamp(grid_cols, MAX_COLS_DEFAULT);
         r = pad_row;
         c = pad_col;
         up = 1'b0;
         mid = 1'b0;

         // Shift the column through both line buffers.
         if (c < LINE_DEPTH) begin
            up = older_row[c];
            mid = newer_row[c];
            older_row[c] = mid;
            newer_row[c] = cell_bit;
         end
         window = {window[5:0], up, mid, cell_bit};

         // Only interior cells produce a result.
         if (r >= 2 && c >= 2 && r <= rows + 1 && c <= cols + 1) begin
            res.next_value = rule_table[$countones(window)];
            res.row = INDEX_W'(r - 2);
            res.col = INDEX_W'(c - 2);
            res.last = (r == rows + 1 && c == cols + 1);
            next_states.push_back(res);
         end

         // Advance the raster position; the sizes in force now decide the wrap.
         if (c >= cols + 1) begin
            pad_col = 0;
            pad_row = (r >= rows + 1) ? 0 : r + 1;
         end else begin
            pad_col = c + 1;
         end
      endfunction

      // Called for every accepted result transaction.
      function void check_result(input cell_state_type got);
         cell_state_type want;
         if (next_states.size() == 0) begin
            errors++;
            $display("%0t: unexpected result next %0b row %0d col %0d last %0b",
                     $time, got.next_value, got.row, got.col, got.last);
            return;
         end
         want = next_states.pop_front();
         if (got !== want) begin
            errors++;
            $display("%0t: expected next %0b row %0d col %0d last %0b,",
                     $time, want.next_value, want.row, want.col, want.last,
                     " actual next %0b row %0d col %0d last %0b",
                     got.next_value, got.row, got.col, got.last);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   cavs_req_if req_if ();
   cavs_rsp_if rsp_if ();

   vote_scoreboard_type sb = new();

   int          gap_pct = 0;
   int          long_hold = 0;
   int unsigned cells_sent = 0;

   wire req_fire = req_if.valid & req_if.ready;
   wire rsp_fire = rsp_if.valid & rsp_if.ready;

   ca_anneal_vote_stencil i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Observe both channels at each rising edge.
   always @(posedge clock) begin
      if (!reset && req_fire) sb.note_cell(req_if.cell_value);
      if (!reset && rsp_fire)
         sb.check_result(cell_state_type'{rsp_if.next_value, rsp_if.cell_row,
                                          rsp_if.cell_col, rsp_if.frame_last});
   end

   // Result receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (long_hold > 0) begin
            stall_left = long_hold - 1;
            long_hold = 0;
            rsp_if.ready <= 1'b0;
         end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            stall_left = $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when nothing is accepted for too long.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < HANG_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Offer one cell, with a random gap in front of it, and wait until it is taken.
   task automatic send_cell(input logic value);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cell_value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      cells_sent++;
   endtask

   // Send a run of cells, each set with the given percent chance.
   task automatic send_frame(input int unsigned count, input int density);
      repeat (count) send_cell($urandom_range(0, 99) < density);
   endtask

   // Stop offering cells and wait until every expected result has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers on back-to-back cycles.
   task automatic set_grid(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols,
                           input logic [RULE_W-1:0] rule);
      csr_write_en <= 1'b1;
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      sb.write_reg(CSR_GRID_ROWS, rows);
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      sb.write_reg(CSR_GRID_COLS, cols);
      csr_index <= CSR_RULE_TABLE;
      csr_wdata <= CSR_DATA_W'(rule);
      @(posedge clock);
      sb.write_reg(CSR_RULE_TABLE, CSR_DATA_W'(rule));
      csr_write_en <= 1'b0;
   endtask

   // Main stimulus sequence.
   initial begin
      int unsigned       rows;
      int unsigned       cols;
      logic [RULE_W-1:0] rule;
      int unsigned       start_count;
      int                phase;
      int                density;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.cell_value = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_GRID_ROWS;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero sizes act as a single interior cell; all-ones and all-zeros neighborhoods.
      set_grid(11'd0, 11'd0, RULE_TABLE_RESET);
      send_frame(sb.frame_cells(), 100);
      send_frame(sb.frame_cells(), 0);
      wait_drained();
      set_grid(11'd1, 11'd1, '1);
      send_frame(sb.frame_cells(), 0);

      // Sizes shrink at a row boundary in mid-frame: after four padded rows of a
      // 6x5 grid, the grid becomes 3x3, so padded row four is the last row and
      // only its first five cells belong to the frame.
      wait_drained();
      gap_pct = 10;
      set_grid(11'd6, 11'd5, RULE_W'($urandom_range(0, 1023)));
      send_frame(4 * 7, 50);
      wait_drained();
      set_grid(11'd3, 11'd3, sb.rule_table);
      send_frame(5, 50);

      // Oversized row count acts as the maximum: six padded rows of one column,
      // then the grid shrinks to five rows, so padded row six ends the frame.
      wait_drained();
      set_grid(11'd2047, 11'd1, RULE_W'($urandom_range(0, 1023)));
      send_frame(6 * 3, 50);
      wait_drained();
      set_grid(11'd5, 11'd1, sb.rule_table);
      send_frame(3, 50);

      // Oversized column count acts as the maximum: ten cells of the first row,
      // then eight columns, so the next cell ends that row and two rows follow.
      wait_drained();
      set_grid(11'd1, 11'd2047, RULE_W'($urandom_range(0, 1023)));
      send_frame(10, 50);
      wait_drained();
      set_grid(11'd1, 11'd8, sb.rule_table);
      send_frame(1 + 2 * 10, 50);

      // Random grids, rules and densities, mostly small.
      start_count = cells_sent;
      phase = 0;
      while (cells_sent - start_count < RANDOM_CELLS) begin
         wait_drained();
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 5;
            default: gap_pct = 20;
         endcase
         rows = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         cols = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 8);
         case ($urandom_range(0, 5))
            0: rule = RULE_TABLE_RESET;
            1: rule = '0;
            2: rule = '1;
            default: rule = RULE_W'($urandom_range(0, 1023));
         endcase
         // One phase holds off the receiver while the sender keeps going.
         if (phase == 0) begin
            rows = 4;
            cols = 6;
            long_hold = LONG_HOLD;
         end
         set_grid(SIZE_W'(rows), SIZE_W'(cols), rule);
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
               0: density = 10;
               1: density = 50;
               default: density = 90;
            endcase
            if (cells_sent - start_count < RANDOM_CELLS)
               send_frame(sb.frame_cells(), density);
         end
         phase++;
      end

      // Final stretch at full rate on both sides.
      wait_drained();
      gap_pct = 0;
      set_grid(11'd5, 11'd7, RULE_TABLE_RESET);
      repeat (3) send_frame(sb.frame_cells(), 50);
      wait_drained();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
